[src/gfp_pkg.sv]
// Package for the gyro frame parser: sync value, frame length and stream widths.
// Used by gyro_frame_parser_core and its port checker; depends on nothing else.
`default_nettype none

package gfp_pkg;

    // Byte that forms the two-byte sync header.
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;

    // Payload bytes in one frame: rate, angle and checksum, two bytes each.
    localparam int unsigned PAYLOAD_LEN = 6;

    // Bias added to the rate plus angle sum to form the expected checksum.
    localparam logic [15:0] SUM_BIAS   = 16'hFFFF;

    // Field widths of one result beat.
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned ANGLE_W    = 17;
    localparam int unsigned SUM_W      = 16;

    // Stream data widths, padded to whole bytes.
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_FIELDS_W = RATE_W + ANGLE_W + 1 + SUM_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[src/gyro_frame_parser_core.sv]
// Top level of the gyro frame parser: sync hunt, payload collection and result register.
// Depends on gfp_pkg for the sync value, frame length and stream widths.
`default_nettype none

// Channel   Dir  Beat contents                          Handshake
// s_*       in   rx_byte, one serial byte               s_tvalid / s_tready
// m_*       out  rate, angle, checksum_ok, received_sum m_tvalid / m_tready
//
// An accepted byte is held in the input register and passes through the parser
// logic into the result register when that register can move. One byte can be
// accepted every cycle unless a stalled result holds the full input register;
// a result appears on the eighth byte of a frame.
// aresetn is synchronous and active low; it clears the phase, the byte count and
// both valid flags. The payload bytes are not reset.
// A stalled result holds the input register only while that register is full.
module gyro_frame_parser_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [7:0] rx_byte
    input  wire logic [gfp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [15:0] rate, [32:16] angle, [33] checksum_ok, [49:34] received_sum,
    //          upper bits zero
    output logic [gfp_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    localparam int unsigned StoreDepth = gfp_pkg::PAYLOAD_LEN - 1;
    localparam int unsigned PadW       = gfp_pkg::M_TDATA_W - gfp_pkg::M_FIELDS_W;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_DATA
    } phase_t;

    // Input register.
    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_byte_reg;

    // Parser state.
    phase_t                       phase_reg, phase_next;
    logic [2:0]                   count_reg, count_next;
    logic [7:0]                   store_reg [StoreDepth];

    // Result register.
    logic                         m_valid_reg, m_valid_next;
    logic [gfp_pkg::RATE_W-1:0]   rate_reg;
    logic [gfp_pkg::ANGLE_W-1:0]  angle_reg;
    logic                         ok_reg;
    logic [gfp_pkg::SUM_W-1:0]    sum_reg;

    // Internal control.
    logic                         in_fire;
    logic                         out_free;
    logic                         work;
    logic                         store_we;
    logic                         frame_done;
    logic [2:0]                   cnt_sat;

    // Words of the completed frame.
    logic [15:0]                  rate_w;
    logic [15:0]                  ang_w;
    logic [15:0]                  sum_w;
    logic [15:0]                  expect_w;
    logic [gfp_pkg::ANGLE_W-1:0]  neg_ang;

    // Handshake: the input register frees whenever the result register can move.
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign work     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Frame words are little-endian; the last checksum byte is the current one.
    assign rate_w   = {store_reg[1], store_reg[0]};
    assign ang_w    = {store_reg[3], store_reg[2]};
    assign sum_w    = {in_byte_reg, store_reg[4]};
    assign expect_w = 16'(rate_w + ang_w + gfp_pkg::SUM_BIAS);
    assign neg_ang  = gfp_pkg::ANGLE_W'(17'd0 - {ang_w[15], ang_w});

    // Parser step for the byte held in the input register.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        store_we   = 1'b0;
        frame_done = 1'b0;
        // A count beyond the last stored byte is taken as the final byte.
        cnt_sat    = (count_reg > 3'(gfp_pkg::PAYLOAD_LEN - 2)) ?
                     3'(gfp_pkg::PAYLOAD_LEN - 1) : count_reg;
        if (work) begin
            unique case (phase_reg)
                PH_SYNC2: begin
                    // A broken sync drops this byte and restarts the hunt.
                    if (in_byte_reg == gfp_pkg::SYNC_BYTE) begin
                        phase_next = PH_DATA;
                        count_next = 3'd0;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (cnt_sat < 3'(StoreDepth)) begin
                        store_we   = 1'b1;
                        count_next = 3'(cnt_sat + 3'd1);
                    end else begin
                        frame_done = 1'b1;
                        phase_next = PH_HUNT;
                        count_next = 3'd0;
                    end
                end
                default: begin
                    // Hunting, and the unused phase code behaves the same.
                    phase_next = (in_byte_reg == gfp_pkg::SYNC_BYTE) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    // Valid flags of the two registers.
    always_comb begin
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (work) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        m_valid_next = out_free ? frame_done : m_valid_reg;
    end

    // State, payload store and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_HUNT;
            count_reg    <= 3'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
        end
        if (in_fire) begin
            in_byte_reg <= s_tdata[7:0];
        end
        if (store_we) begin
            store_reg[cnt_sat] <= in_byte_reg;
        end
        if (frame_done) begin
            rate_reg  <= rate_w;
            angle_reg <= neg_ang;
            ok_reg    <= (expect_w == sum_w);
            sum_reg   <= sum_w;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PadW{1'b0}}, sum_reg, ok_reg, angle_reg, rate_reg};

endmodule

`default_nettype wire

[src/gfp_port_checker.sv]
// Port-level checker for gyro_frame_parser_core, bound to every instance of it.
// Depends on gfp_pkg for the result beat layout.
`default_nettype none

module gfp_port_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [gfp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    logic [15:0] rate_f;
    logic [15:0] ang_f;
    logic        ok_f;
    logic [15:0] sum_f;

    assign rate_f = m_tdata[15:0];
    assign ang_f  = m_tdata[31:16];
    assign ok_f   = m_tdata[33];
    assign sum_f  = m_tdata[49:34];

    // A stalled result beat keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // With no result pending the input side is always open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // A fresh result follows an input beat that went through the input register first.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a preceding input beat");

    // The checksum flag agrees with the words shown: sum == rate - angle - 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ok_f == (sum_f == 16'(rate_f - ang_f - 16'd1))))
        else $error("checksum flag disagrees with the result words");

endmodule

bind gyro_frame_parser_core gfp_port_checker u_gfp_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
